FILE: design/hkde_pkg.sv
// ----------------------------------------------------------------------------
// hkde_pkg: shared types and constants
// Payload structs, command/status bundles and envelope constants for the
// haptic kick and decay envelope.
// ----------------------------------------------------------------------------
package hkde_pkg;

  localparam int DUTY_WIDTH = 10;
  localparam logic [DUTY_WIDTH-1:0] DUTY_MAX = '1;

  localparam int MODE_W     = 2;
  localparam int TIME_W     = 32;
  localparam int LEVEL_W    = 11;
  localparam int LEN_W      = 16;
  localparam int KICK_LEN_W = 8;
  localparam int KICK_LVL_W = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // weighted sum 35*span+65*left, at most 100*(2^32-1)
  localparam int SUM_W  = 39;
  localparam int PROD_W = DUTY_WIDTH + SUM_W;
  localparam int QCNT_W = $clog2(DUTY_WIDTH);

  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PULSE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STOP  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KICK_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KICK_LEVEL   = 2'd2;

  localparam logic [LEVEL_W-1:0]    LEVEL_FULL     = 11'd1024;
  localparam logic [SUM_W-1:0]      HOLD_BASE      = SUM_W'(18432);
  localparam logic [SUM_W-1:0]      HOLD_SLOPE     = SUM_W'(37);
  localparam logic [SUM_W-1:0]      HOLD_DIVISOR   = SUM_W'(102400);
  localparam logic [SUM_W-1:0]      DECAY_FLOOR    = SUM_W'(35);
  localparam logic [SUM_W-1:0]      DECAY_RISE     = SUM_W'(65);
  localparam logic [SUM_W-1:0]      PERCENT        = SUM_W'(100);
  localparam logic [LEN_W:0]        KICK_TAIL_MS   = 17'd10;
  localparam logic                  PULSE_EN_RST   = 1'b1;
  localparam logic [KICK_LEN_W-1:0] KICK_LEN_RST   = 8'd18;
  localparam logic [KICK_LVL_W-1:0] KICK_LVL_RST   = 10'd1000;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [TIME_W-1:0]  now_ms;
    logic [LEVEL_W-1:0] level;
    logic [LEN_W-1:0]   length_ms;
  } in_item_t;

  typedef struct packed {
    logic [DUTY_WIDTH-1:0] drive_duty;
    logic                  active;
  } out_item_t;

  typedef struct packed {
    logic load_in;
    logic decode;
    logic mul;
    logic div_start;
    logic commit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_calc;
    logic div_busy;
    logic div_done;
  } status_t;

endpackage

FILE: design/haptic_kick_decay_envelope.sv
// ----------------------------------------------------------------------------
// haptic_kick_decay_envelope: vibration motor PWM envelope
// Kick drive at pulse start, then a linear decay toward 35% of a hold level.
//
//   channel | ports                                   | moves
//   --------+-----------------------------------------+------------------------
//   in      | in_valid, in_stall, in_data             | one request per item
//   out     | out_valid, out_stall, out_data          | one result per request
//   cfg     | cfg_valid, cfg_ready, cfg_index/_data   | one register write
//
// A request that needs no arithmetic goes from decode straight to the finish step;
// a pulse start or decay tick also passes the multiply, divider start and divider
// wait steps, held by the bit-per-cycle divider shared by hold and decay math.
// Reset is synchronous on rst_n low; all envelope state reads zero after it.
// A finished result waits in the output register under out_stall while the
// next request is accepted; cfg_ready is always high.
// ----------------------------------------------------------------------------
module haptic_kick_decay_envelope (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  hkde_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output hkde_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hkde_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hkde_pkg::CFG_DATA_W-1:0]  cfg_data
);

  hkde_pkg::cmd_t    cmd;
  hkde_pkg::status_t st;

  assign cfg_ready = 1'b1;

  hkde_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  hkde_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .out_data  (out_data)
  );

endmodule

FILE: design/hkde_div.sv
// ----------------------------------------------------------------------------
// hkde_div: restoring divider
// One quotient bit per cycle; the quotient is known to fit DUTY_WIDTH bits.
// ----------------------------------------------------------------------------
module hkde_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [hkde_pkg::PROD_W-1:0]      num,
  input  logic [hkde_pkg::SUM_W-1:0]       den,
  output logic                             busy,
  output logic                             done,
  output logic [hkde_pkg::DUTY_WIDTH-1:0]  quot
);

  logic                            busy_r;
  logic                            done_r;
  logic [hkde_pkg::PROD_W-1:0]     rem_r;
  logic [hkde_pkg::PROD_W-1:0]     dsh_r;
  logic [hkde_pkg::DUTY_WIDTH-1:0] q_r;
  logic [hkde_pkg::QCNT_W-1:0]     cnt_r;
  logic                            ge;

  assign ge = (rem_r >= dsh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsh_r <= hkde_pkg::PROD_W'(den) << (hkde_pkg::DUTY_WIDTH - 1);
      cnt_r <= hkde_pkg::QCNT_W'(hkde_pkg::DUTY_WIDTH - 1);
      q_r   <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dsh_r;
      end
      dsh_r <= dsh_r >> 1;
      cnt_r <= cnt_r - 1'b1;
      q_r   <= {q_r[hkde_pkg::DUTY_WIDTH-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;

endmodule

FILE: design/hkde_dp.sv
// ----------------------------------------------------------------------------
// hkde_dp: envelope datapath
// Config registers, pulse timing state, hold/duty registers, shared
// multiplier stage, divider and result register.
// ----------------------------------------------------------------------------
module hkde_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  hkde_pkg::in_item_t                in_data,
  input  logic                              cfg_we,
  input  logic [hkde_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hkde_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  hkde_pkg::cmd_t                    cmd,
  output hkde_pkg::status_t                 st,
  output hkde_pkg::out_item_t               out_data
);

  localparam int LENX_W = hkde_pkg::LEN_W + 1;

  logic                                pulse_en_r;
  logic [hkde_pkg::KICK_LEN_W-1:0]     kick_len_r;
  logic [hkde_pkg::KICK_LVL_W-1:0]     kick_lvl_r;
  logic [hkde_pkg::TIME_W-1:0]         end_r;
  logic [hkde_pkg::TIME_W-1:0]         kick_end_r;
  logic [hkde_pkg::DUTY_WIDTH-1:0]     hold_r;
  logic [hkde_pkg::DUTY_WIDTH-1:0]     duty_r;
  hkde_pkg::in_item_t                  item_r;
  logic                                to_hold_r;
  logic [hkde_pkg::DUTY_WIDTH-1:0]     mul_a_r;
  logic [hkde_pkg::SUM_W-1:0]          mul_b_r;
  logic [hkde_pkg::SUM_W-1:0]          den_r;
  logic [hkde_pkg::PROD_W-1:0]         prod_r;
  hkde_pkg::out_item_t                 out_r;

  logic                                do_start;
  logic                                do_clear;
  logic                                do_decay;
  logic                                cfg_stop;
  logic [hkde_pkg::LEVEL_W-1:0]        lvl_clamp;
  logic [hkde_pkg::SUM_W-1:0]          hold_arg;
  logic [LENX_W-1:0]                   min_len;
  logic [LENX_W-1:0]                   pulse_len;
  logic [hkde_pkg::TIME_W-1:0]         end_nxt;
  logic [hkde_pkg::TIME_W-1:0]         kick_end_nxt;
  logic [hkde_pkg::TIME_W-1:0]         left;
  logic [hkde_pkg::TIME_W-1:0]         span;
  logic [hkde_pkg::SUM_W-1:0]          decay_arg;
  logic [hkde_pkg::SUM_W-1:0]          decay_den;
  logic                                div_busy;
  logic                                div_done;
  logic [hkde_pkg::DUTY_WIDTH-1:0]     div_q;

  always_comb begin
    do_start = 1'b0;
    do_clear = 1'b0;
    do_decay = 1'b0;
    case (item_r.mode)
      hkde_pkg::MODE_PULSE: do_start = pulse_en_r && (item_r.level != '0);
      hkde_pkg::MODE_STOP:  do_clear = 1'b1;
      hkde_pkg::MODE_TICK: begin
        if (end_r != '0) begin
          if (item_r.now_ms >= end_r) begin
            do_clear = 1'b1;
          end else if (item_r.now_ms >= kick_end_r) begin
            do_decay = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign lvl_clamp = (item_r.level > hkde_pkg::LEVEL_FULL) ? hkde_pkg::LEVEL_FULL
                                                           : item_r.level;
  assign hold_arg  = hkde_pkg::HOLD_BASE
                   + hkde_pkg::HOLD_SLOPE * hkde_pkg::SUM_W'(lvl_clamp);

  assign min_len      = LENX_W'(kick_len_r) + hkde_pkg::KICK_TAIL_MS;
  assign pulse_len    = (LENX_W'(item_r.length_ms) < min_len) ? min_len
                                                              : LENX_W'(item_r.length_ms);
  assign end_nxt      = item_r.now_ms + hkde_pkg::TIME_W'(pulse_len);
  assign kick_end_nxt = item_r.now_ms + hkde_pkg::TIME_W'(kick_len_r);

  assign left = end_r - item_r.now_ms;
  assign span = end_r - kick_end_r;

  assign decay_arg = (span == '0) ? hkde_pkg::DECAY_FLOOR
                   : hkde_pkg::DECAY_FLOOR * hkde_pkg::SUM_W'(span)
                   + hkde_pkg::DECAY_RISE  * hkde_pkg::SUM_W'(left);
  assign decay_den = (span == '0) ? hkde_pkg::PERCENT
                   : hkde_pkg::PERCENT * hkde_pkg::SUM_W'(span);

  assign cfg_stop = cfg_we && (cfg_index == hkde_pkg::CFG_PULSE_ENABLE) && !cfg_data[0];

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_en_r <= hkde_pkg::PULSE_EN_RST;
      kick_len_r <= hkde_pkg::KICK_LEN_RST;
      kick_lvl_r <= hkde_pkg::KICK_LVL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hkde_pkg::CFG_PULSE_ENABLE: pulse_en_r <= cfg_data[0];
        hkde_pkg::CFG_KICK_LENGTH:  kick_len_r <= cfg_data[hkde_pkg::KICK_LEN_W-1:0];
        hkde_pkg::CFG_KICK_LEVEL:   kick_lvl_r <= cfg_data[hkde_pkg::KICK_LVL_W-1:0];
        default: ;
      endcase
    end
  end

  // envelope state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_r      <= '0;
      kick_end_r <= '0;
      hold_r     <= '0;
      duty_r     <= '0;
    end else if (cfg_stop || (cmd.decode && do_clear)) begin
      end_r      <= '0;
      kick_end_r <= '0;
      hold_r     <= '0;
      duty_r     <= '0;
    end else if (cmd.decode && do_start) begin
      end_r      <= end_nxt;
      kick_end_r <= kick_end_nxt;
      duty_r     <= hkde_pkg::DUTY_WIDTH'(kick_lvl_r);
    end else if (cmd.commit) begin
      if (to_hold_r) begin
        hold_r <= div_q;
      end else begin
        duty_r <= div_q;
      end
    end
  end

  // operands and result payload
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      item_r <= in_data;
    end
    if (cmd.decode) begin
      to_hold_r <= do_start;
      if (do_start) begin
        mul_a_r <= hkde_pkg::DUTY_MAX;
        mul_b_r <= hold_arg;
        den_r   <= hkde_pkg::HOLD_DIVISOR;
      end else begin
        mul_a_r <= hold_r;
        mul_b_r <= decay_arg;
        den_r   <= decay_den;
      end
    end
    if (cmd.mul) begin
      prod_r <= hkde_pkg::PROD_W'(mul_a_r) * hkde_pkg::PROD_W'(mul_b_r);
    end
    if (cmd.out_load) begin
      out_r.drive_duty <= duty_r;
      out_r.active     <= (end_r != '0);
    end
  end

  hkde_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (prod_r),
    .den   (den_r),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_q)
  );

  assign st.need_calc = do_start || do_decay;
  assign st.div_busy  = div_busy;
  assign st.div_done  = div_done;
  assign out_data     = out_r;

endmodule

FILE: design/hkde_ctrl.sv
// ----------------------------------------------------------------------------
// hkde_ctrl: envelope controller
// Sequences accept, decode, multiply and divide steps and owns the
// request handshakes on both channels.
// ----------------------------------------------------------------------------
module hkde_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  hkde_pkg::status_t  st,
  output hkde_pkg::cmd_t     cmd
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DECODE = 6'b000010,
    ST_MUL    = 6'b000100,
    ST_DIVS   = 6'b001000,
    ST_DIVW   = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt  = st.need_calc ? ST_MUL : ST_FINISH;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DIVS;
      end
      ST_DIVS: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIVW;
      end
      ST_DIVW: begin
        if (st.div_done) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == ST_DECODE)
    else $error("accepted request not decoded");

  a_result_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FINISH)
    else $error("result raised outside finish step");

  a_div_launch: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIVS |=> st.div_busy)
    else $error("divider did not start");

  a_div_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    st.div_done |-> state_r == ST_DIVW)
    else $error("divider finished while not awaited");

endmodule

FILE: sim/hkde_checker.sv
// ----------------------------------------------------------------------------
// hkde_checker: envelope scoreboard
// Watches the request, result and register channels of the haptic envelope,
// keeps its own copy of the envelope state and settings, predicts the duty and
// active flag for every accepted request and compares each accepted result
// with the oldest prediction.
// ----------------------------------------------------------------------------
module hkde_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  hkde_pkg::in_item_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  hkde_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [hkde_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hkde_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending
);
  import hkde_pkg::*;

  typedef longint unsigned u64_t;

  logic                  en_q;
  logic [KICK_LEN_W-1:0] kick_len_q;
  logic [KICK_LVL_W-1:0] kick_lvl_q;
  logic [TIME_W-1:0]     end_ms;
  logic [TIME_W-1:0]     kick_end_ms;
  logic [DUTY_WIDTH-1:0] hold;
  logic [DUTY_WIDTH-1:0] duty;
  out_item_t             duty_expected[$];
  out_item_t             want;
  int                    mismatches = 0;

  function automatic logic [DUTY_WIDTH-1:0] clamp_duty(input u64_t d);
    return (d > u64_t'(DUTY_MAX)) ? DUTY_MAX : DUTY_WIDTH'(d);
  endfunction

  function automatic void clear_envelope();
    end_ms      = '0;
    kick_end_ms = '0;
    hold        = '0;
    duty        = '0;
  endfunction

  function automatic void write_register(input logic [CFG_IDX_W-1:0]  idx,
                                         input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_PULSE_ENABLE: begin
        en_q = val[0];
        if (!val[0]) clear_envelope();
      end
      CFG_KICK_LENGTH: kick_len_q = val[KICK_LEN_W-1:0];
      CFG_KICK_LEVEL:  kick_lvl_q = val[KICK_LVL_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic out_item_t next_envelope(input in_item_t req);
    u64_t              lvl;
    u64_t              left;
    u64_t              span;
    u64_t              hold64;
    logic [TIME_W-1:0] left32;
    logic [TIME_W-1:0] span32;
    logic [TIME_W-1:0] min_len;
    logic [TIME_W-1:0] len32;
    out_item_t         res;
    case (req.mode)
      MODE_PULSE: if (en_q && req.level != '0) begin
        lvl = (req.level > LEVEL_FULL) ? u64_t'(LEVEL_FULL) : u64_t'(req.level);
        hold = clamp_duty((u64_t'(DUTY_MAX) * (18432 + 37 * lvl)) / 102400);
        min_len = TIME_W'(kick_len_q) + 32'd10;
        len32 = TIME_W'(req.length_ms);
        kick_end_ms = req.now_ms + TIME_W'(kick_len_q);
        end_ms = req.now_ms + ((len32 < min_len) ? min_len : len32);
        duty = clamp_duty(u64_t'(kick_lvl_q));
      end
      MODE_STOP: clear_envelope();
      MODE_TICK: if (end_ms != '0) begin
        if (req.now_ms >= end_ms) begin
          clear_envelope();
        end else if (req.now_ms >= kick_end_ms) begin
          left32 = end_ms - req.now_ms;
          span32 = end_ms - kick_end_ms;
          left = left32;
          span = span32;
          hold64 = hold;
          if (span == 0) duty = clamp_duty((hold64 * 35) / 100);
          else duty = clamp_duty((hold64 * (35 * span + 65 * left)) / (100 * span));
        end
      end
      default: ;
    endcase
    res.drive_duty = duty;
    res.active     = (end_ms != '0);
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      en_q       = PULSE_EN_RST;
      kick_len_q = KICK_LEN_RST;
      kick_lvl_q = KICK_LVL_RST;
      clear_envelope();
      duty_expected.delete();
    end else begin
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      if (out_valid && !out_stall) begin
        if (duty_expected.size() == 0) begin
          $error("unexpected result: drive_duty %0d active %0b",
                 out_data.drive_duty, out_data.active);
          mismatches++;
        end else begin
          want = duty_expected.pop_front();
          if (out_data.drive_duty !== want.drive_duty) begin
            $error("drive_duty: expected %0d, got %0d", want.drive_duty,
                   out_data.drive_duty);
            mismatches++;
          end
          if (out_data.active !== want.active) begin
            $error("active: expected %0b, got %0b", want.active, out_data.active);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) duty_expected.push_back(next_envelope(in_data));
    end
    fail_count <= mismatches;
    pending    <= duty_expected.size();
  end

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: haptic kick and decay envelope regression
// Resets the envelope, runs a directed sequence over kicks, decay, stops and
// time wrap, then well-formed pulse sequences with random content mixed with
// random requests under several register settings. Both channels idle at
// random; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import hkde_pkg::*;

  localparam logic [MODE_W-1:0]    MODE_SPARE     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE      = 2'd3;
  localparam int                   GAP_MAX        = 19;
  localparam int                   WATCHDOG_LIMIT = 2000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b1;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  int                    fail_count;
  int                    pending;
  logic [TIME_W-1:0]     ms_clock     = '0;
  logic [KICK_LEN_W-1:0] kick_len_now = KICK_LEN_RST;
  bit                    steady       = 1'b0;
  int                    phase_count  = 0;
  int                    quiet_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  haptic_kick_decay_envelope DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  hkde_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("haptic_kick_decay_envelope regression: fail");
      $finish;
    end
  end

  // stall the result channel for a drawn number of cycles before each result
  initial begin : result_sink
    int hold_off;
    forever begin
      hold_off = steady ? 0 : $urandom_range(0, GAP_MAX);
      if (hold_off > 0) begin
        out_stall <= 1'b1;
        repeat (hold_off) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid && !out_stall));
    end
  end

  task automatic send_req(input logic [MODE_W-1:0] m, input logic [TIME_W-1:0] now,
                          input logic [LEVEL_W-1:0] lvl, input logic [LEN_W-1:0] len);
    int       gap;
    in_item_t req;
    gap = steady ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.mode      = m;
    req.now_ms    = now;
    req.level     = lvl;
    req.length_ms = len;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall !== 1'b0);
    phase_count++;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  task automatic drain_results();
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_settings(input logic en, input logic [KICK_LEN_W-1:0] klen,
                                input logic [KICK_LVL_W-1:0] klvl);
    logic [CFG_DATA_W-1:0] pad;
    pad = CFG_DATA_W'($urandom);
    in_valid <= 1'b0;
    drain_results();
    cfg_write(CFG_KICK_LENGTH, {pad[1:0], klen});
    cfg_write(CFG_KICK_LEVEL, klvl);
    cfg_write(CFG_SPARE, ~pad);
    cfg_write(CFG_PULSE_ENABLE, {pad[CFG_DATA_W-1:1], en});
    cfg_valid <= 1'b0;
    kick_len_now = klen;
  endtask

  // pulse start followed by ticks through kick and decay, ending at the pulse end, on a stop or at random
  task automatic pulse_episode();
    logic [LEVEL_W-1:0] lvl;
    logic [LEN_W-1:0]   len;
    logic [TIME_W-1:0]  start;
    int                 dur;
    int                 offset;
    int                 pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) lvl = '0;
    else if (pick == 1) lvl = LEVEL_W'($urandom_range(1025, 2047));
    else lvl = LEVEL_W'($urandom_range(1, 1024));
    if ($urandom_range(0, 9) == 0) len = LEN_W'($urandom);
    else len = LEN_W'($urandom_range(0, 400));
    ms_clock = ms_clock + TIME_W'($urandom_range(0, 60));
    start = ms_clock;
    send_req(MODE_PULSE, start, lvl, len);
    dur = int'(kick_len_now) + 10;
    if (int'(len) > dur) dur = int'(len);
    offset = 0;
    forever begin
      pick = $urandom_range(0, 15);
      if (pick == 0) break;
      if (pick == 1) begin
        send_req(MODE_STOP, ms_clock, LEVEL_W'($urandom), LEN_W'($urandom));
        break;
      end
      if (pick == 2 && offset < int'(kick_len_now)) offset = int'(kick_len_now);
      else if (pick == 3) offset = dur;
      else offset = offset + $urandom_range(0, dur / 6 + 2);
      ms_clock = start + TIME_W'(offset);
      send_req(MODE_TICK, ms_clock, LEVEL_W'($urandom), LEN_W'($urandom));
      if (offset >= dur) break;
    end
  endtask

  task automatic noise_item();
    logic [TIME_W-1:0] now;
    if ($urandom_range(0, 1) == 0) now = $urandom;
    else now = ms_clock + TIME_W'($urandom_range(0, 100));
    send_req(MODE_W'($urandom), now, LEVEL_W'($urandom), LEN_W'($urandom));
  endtask

  task automatic run_mix(input int target);
    phase_count = 0;
    if ($urandom_range(0, 2) == 0) ms_clock = 32'hFFFF_FE00;
    else ms_clock = $urandom;
    while (phase_count < target) begin
      steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 8) pulse_episode();
      else noise_item();
    end
  endtask

  initial begin : stimulus
    int p;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_req(MODE_TICK, 32'd0, '0, '0);
    send_req(MODE_SPARE, '1, '1, '1);
    send_req(MODE_PULSE, 32'd500, 11'd0, 16'd300);
    send_req(MODE_PULSE, 32'd1000, LEVEL_FULL, 16'd0);
    send_req(MODE_TICK, 32'd1010, '0, '0);
    send_req(MODE_TICK, 32'd1018, '0, '0);
    send_req(MODE_TICK, 32'd1023, '0, '0);
    send_req(MODE_TICK, 32'd1027, '0, '0);
    send_req(MODE_TICK, 32'd1028, '0, '0);
    send_req(MODE_PULSE, 32'd2000, '1, '1);
    send_req(MODE_TICK, 32'd2100, '0, '0);
    send_req(MODE_STOP, 32'd2200, '0, '0);
    send_req(MODE_TICK, 32'd2300, '0, '0);
    send_req(MODE_PULSE, 32'd3000, 11'd1, 16'd100);
    send_req(MODE_PULSE, 32'd3050, 11'd512, 16'd200);
    send_req(MODE_TICK, 32'd3100, '0, '0);
    send_req(MODE_PULSE, 32'hFFFF_FF9C, 11'd700, 16'd100);
    send_req(MODE_TICK, 32'hFFFF_FFFF, '0, '0);
    send_req(MODE_PULSE, 32'hFFFF_FFF0, 11'd300, 16'd300);
    send_req(MODE_TICK, 32'hFFFF_FFF8, '0, '0);
    send_req(MODE_PULSE, 32'd5, 11'd1023, 16'd40);
    send_req(MODE_TICK, 32'd30, '0, '0);

    // disable with the pulse still running
    apply_settings(1'b0, 8'd255, 10'd0);
    send_req(MODE_TICK, 32'd31, '0, '0);
    send_req(MODE_PULSE, 32'd40, LEVEL_FULL, 16'd100);
    run_mix(20);

    apply_settings(1'b1, 8'd255, 10'd0);
    run_mix(90);
    apply_settings(1'b1, 8'd0, 10'd1023);
    run_mix(90);
    for (p = 0; p < 5; p++) begin
      apply_settings(1'b1, KICK_LEN_W'($urandom), KICK_LVL_W'($urandom));
      run_mix(90);
    end
    apply_settings(1'b1, KICK_LEN_RST, KICK_LVL_RST);
    run_mix(60);

    in_valid <= 1'b0;
    drain_results();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("haptic_kick_decay_envelope regression: pass");
    end else begin
      $display("haptic_kick_decay_envelope regression: fail");
    end
    $finish;
  end

endmodule
